### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the find and replace core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stream find and replace modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_FIND    = 8;
    localparam int MAX_REPLACE = 8;
    localparam int WIN_BYTES   = 8;

    typedef enum logic [1:0] {
        CFG_FIND_PAT = 2'd0,
        CFG_FIND_LEN = 2'd1,
        CFG_REP_PAT  = 2'd2,
        CFG_REP_LEN  = 2'd3
    } t_cfg_idx;

    // Effective configuration, lengths already clamped.
    typedef struct packed {
        logic [63:0] find_pat;
        logic [3:0]  pat_len;
        logic [63:0] rep_pat;
        logic [3:0]  rep_len;
    } t_cfg;

    // One run of results caused by a single item.
    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  cnt;
        logic        has;
        logic        text_end;
        logic [31:0] total;
    } t_run;

    typedef struct packed {
        logic [2:0]  pend_cnt;
        logic [31:0] match_cnt;
    } t_step_stat;

endpackage

### src/sfr_in_if.sv
// ----------------------------------------------------------------------------
// sfr_in_if
// Input channel: one text byte per item.
// ----------------------------------------------------------------------------
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_last;

    modport source (output valid, output in_byte, output text_last, input ready);
    modport sink (input valid, input in_byte, input text_last, output ready);
endinterface

### src/sfr_out_if.sv
// ----------------------------------------------------------------------------
// sfr_out_if
// Output channel: one result byte or end marker per item.
// ----------------------------------------------------------------------------
interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        run_last;
    logic        text_end;
    logic [31:0] match_total;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output text_end, output match_total, input ready);
    modport sink (input valid, input out_byte, input has_byte, input run_last,
                  input text_end, input match_total, output ready);
endinterface

### src/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration registers with length clamping.
// ----------------------------------------------------------------------------
module sfr_cfg_regs import sfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output t_cfg        o_cfg
);

    logic [63:0] r_find_pat;
    logic [3:0]  r_pat_len;
    logic [63:0] r_rep_pat;
    logic [3:0]  r_rep_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_pat <= '0;
            r_pat_len  <= 4'd1;
            r_rep_pat  <= '0;
            r_rep_len  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FIND_PAT: r_find_pat <= i_cfg_data;
                CFG_FIND_LEN: r_pat_len  <= i_cfg_data[3:0];
                CFG_REP_PAT:  r_rep_pat  <= i_cfg_data;
                CFG_REP_LEN:  r_rep_len  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.find_pat = r_find_pat;
        o_cfg.rep_pat  = r_rep_pat;
        if (r_pat_len == 4'd0) begin
            o_cfg.pat_len = 4'd1;
        end else if (r_pat_len > 4'(MAX_FIND)) begin
            o_cfg.pat_len = 4'(MAX_FIND);
        end else begin
            o_cfg.pat_len = r_pat_len;
        end
        if (r_rep_len > 4'(MAX_REPLACE)) begin
            o_cfg.rep_len = 4'(MAX_REPLACE);
        end else begin
            o_cfg.rep_len = r_rep_len;
        end
    end

endmodule

### src/sfr_step.sv
// ----------------------------------------------------------------------------
// sfr_step
// Pending window, match counter and the per-item match and shift logic.
// ----------------------------------------------------------------------------
module sfr_step import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_adv,
    output t_run       o_run,
    output t_step_stat o_stat
);

    logic [7:0]  r_win [WIN_BYTES];
    logic [2:0]  r_pend;
    logic [31:0] r_total;

    logic [7:0]           w [WIN_BYTES];
    logic [63:0]          w_pack;
    logic [3:0]           wn;
    logic [WIN_BYTES-1:0] pfx;
    logic [WIN_BYTES-1:0] ok;
    logic [3:0]           jsel;
    logic                 full;
    logic [31:0]          n_total;
    logic [3:0]           emit_cnt;
    logic [63:0]          n_win_pack;
    logic [2:0]           n_pend;

    always_comb begin
        wn = {1'b0, r_pend} + 4'd1;
        for (int i = 0; i < WIN_BYTES; i++) begin
            w[i] = (3'(i) == r_pend) ? i_byte : r_win[i];
            w_pack[8*i +: 8] = w[i];
        end

        // pfx[j]: the bytes from j to the newest one are a prefix of the pattern.
        for (int j = 0; j < WIN_BYTES; j++) begin
            pfx[j] = 1'b1;
            for (int i = 0; i < WIN_BYTES; i++) begin
                if (i + j < WIN_BYTES) begin
                    if (4'(j) < wn && 4'(i) < (wn - 4'(j))) begin
                        if (w[3'(i + j)] != i_cfg.find_pat[8*i +: 8]) begin
                            pfx[j] = 1'b0;
                        end
                    end
                end
            end
            ok[j] = (4'(j) >= wn) || (((wn - 4'(j)) < i_cfg.pat_len) && pfx[j]);
        end

        full = (wn == i_cfg.pat_len) && pfx[0];

        jsel = 4'(WIN_BYTES);
        for (int j = WIN_BYTES - 1; j >= 0; j--) begin
            if (ok[j]) begin
                jsel = 4'(j);
            end
        end

        n_total = (full && r_total != '1) ? r_total + 32'd1 : r_total;

        if (full) begin
            o_run.bytes = i_cfg.rep_pat;
            emit_cnt    = i_cfg.rep_len;
        end else begin
            o_run.bytes = w_pack;
            emit_cnt    = i_last ? wn : jsel;
        end
        o_run.cnt = emit_cnt;
        o_run.has = 1'b1;
        if (i_last && emit_cnt == 4'd0) begin
            o_run.cnt   = 4'd1;
            o_run.has   = 1'b0;
            o_run.bytes = '0;
        end
        o_run.text_end = i_last;
        o_run.total    = n_total;

        n_win_pack = w_pack >> {jsel, 3'b000};
        n_pend     = (full || i_last) ? 3'd0 : 3'(wn - jsel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_total <= '0;
        end else if (i_adv) begin
            r_pend  <= n_pend;
            r_total <= i_last ? 32'd0 : n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < WIN_BYTES; i++) begin
                r_win[i] <= n_win_pack[8*i +: 8];
            end
        end
    end

    assign o_stat.pend_cnt  = r_pend;
    assign o_stat.match_cnt = r_total;

endmodule

### src/sfr_emit.sv
// ----------------------------------------------------------------------------
// sfr_emit
// Result register: shifts a run of up to eight results out one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module sfr_emit import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_run       i_run,
    output logic       o_free,
    sfr_out_if.source  o_out
);

    logic [63:0] r_buf;
    logic [3:0]  r_rem;
    logic        r_has;
    logic        r_end;
    logic [31:0] r_total;
    logic        pop;

    assign pop    = (r_rem != 4'd0) && o_out.ready;
    assign o_free = (r_rem == 4'd0) || (r_rem == 4'd1 && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_run.cnt;
        end else if (pop) begin
            r_rem <= r_rem - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf   <= i_run.bytes;
            r_has   <= i_run.has;
            r_end   <= i_run.text_end;
            r_total <= i_run.total;
        end else if (pop) begin
            r_buf <= {8'd0, r_buf[63:8]};
        end
    end

    assign o_out.valid       = (r_rem != 4'd0);
    assign o_out.out_byte    = r_buf[7:0];
    assign o_out.has_byte    = r_has;
    assign o_out.run_last    = (r_rem == 4'd1);
    assign o_out.text_end    = r_end && (r_rem == 4'd1);
    assign o_out.match_total = r_total;

endmodule

### src/stream_find_replace_core.sv
// An accepted item is registered in the input register; its results are computed
// combinationally and loaded, once it is free, into the output register that offers them.
// Throughput: one item per cycle while each item yields at most one result and the
// output is ready; an item that yields several results holds the single output
// register until all of them have been taken.
// Reset: synchronous, active low; clears the pending count, match count and valid
// state, and returns the configuration to its defaults.
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Byte stream find and replace with a pending window and match count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stream_find_replace_core import sfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    sfr_in_if.sink      i_in,
    sfr_out_if.source   o_out
);

    t_cfg       cfg;
    t_run       run;
    t_step_stat stat;

    logic       r_in_v;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       emit_free;
    logic       need_emit;
    logic       consume;

    sfr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sfr_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_adv   (consume),
        .o_run   (run),
        .o_stat  (stat)
    );

    sfr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume && need_emit),
        .i_run   (run),
        .o_free  (emit_free),
        .o_out   (o_out)
    );

    assign need_emit  = (run.cnt != 4'd0);
    assign consume    = r_in_v && (!need_emit || emit_free);
    assign i_in.ready = !r_in_v || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in.ready) begin
            r_in_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.text_last;
        end
    end

    `ASSERT_IMP(a_bare_marker_ends_text, i_clk, i_rst_n, o_out.valid && !o_out.has_byte, o_out.out_byte == 8'd0 && o_out.text_end && o_out.run_last)
    `ASSERT_IMP(a_text_end_on_run_last, i_clk, i_rst_n, o_out.valid && o_out.text_end, o_out.run_last)
    `ASSERT_NXT(a_last_clears_state, i_clk, i_rst_n, consume && r_in_last, stat.pend_cnt == 3'd0 && stat.match_cnt == 32'd0)

endmodule
